// ===== design/pfmp_pkg.sv =====
// shared constants, widths and state type for the prime-field modular power block
// no dependencies
`timescale 1ns / 1ps

package pfmp_pkg;

  localparam int FIELD_W   = 30;
  localparam int EXP_W     = 64;
  localparam int MUL_CNT_W = $clog2(FIELD_W);
  localparam int EXP_CNT_W = $clog2(EXP_W);

  // field prime and the group order used to fold the exponent
  localparam logic [FIELD_W-1:0] PRIME = 30'd1000000007;
  localparam logic [FIELD_W-1:0] ORDER = 30'd1000000006;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LIFT,
    ST_ROUND,
    ST_WAIT,
    ST_EMIT
  } pfmp_state_t;

endpackage

// ===== design/pfmp_if.sv =====
// valid/ready channel interfaces for the input and result items
// depends on pfmp_pkg
`timescale 1ns / 1ps

interface pfmp_in_if import pfmp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [FIELD_W-1:0] base;
  logic signed [EXP_W-1:0]   exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface pfmp_out_if import pfmp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] power;

  modport source (output valid, output power, input ready);
  modport sink   (input valid, input power, output ready);
endinterface

// ===== design/pfmp_mulmod.sv =====
// bit-serial modular multiplier, one bit of op_a per cycle, msb first
// depends on pfmp_pkg; operands must already be below the prime
`timescale 1ns / 1ps

module pfmp_mulmod import pfmp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [FIELD_W-1:0] op_a,
  input  logic [FIELD_W-1:0] op_b,
  output logic               done,
  output logic [FIELD_W-1:0] product
);

  localparam logic [MUL_CNT_W-1:0] CNT_LAST = MUL_CNT_W'(FIELD_W - 1);
  localparam logic [FIELD_W:0]     PRIME_X  = {1'b0, PRIME};

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FIELD_W-1:0]   a_r, a_nxt;
  logic [FIELD_W-1:0]   b_r, b_nxt;
  logic [FIELD_W-1:0]   acc_r, acc_nxt;

  logic [FIELD_W:0] dbl, dbl_red, sum, sum_red;

  // acc = 2*acc + bit*b mod p, two conditional subtracts
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= PRIME_X) ? dbl - PRIME_X : dbl;
    sum     = dbl_red + (a_r[FIELD_W-1] ? {1'b0, b_r} : '0);
    sum_red = (sum >= PRIME_X) ? sum - PRIME_X : sum;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = op_a;
      b_nxt    = op_b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      a_nxt   = {a_r[FIELD_W-2:0], 1'b0};
      acc_nxt = sum_red[FIELD_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== design/prime_field_modular_power_top.sv =====
// top level: base^exponent mod 1000000007 by right-to-left square-and-multiply
// depends on pfmp_pkg, pfmp_if (pfmp_in_if, pfmp_out_if) and pfmp_mulmod
`timescale 1ns / 1ps

//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+-----------------------------------------
//  in_ch     | in  | valid/ready  | base[29:0], exponent[63:0] signed
//  out_ch    | out | valid/ready  | power[29:0]
//
//  one item at a time: the exponent is folded modulo p-1 bit by bit, then one
//  square-and-multiply round runs per bit of the folded exponent (at most 30 bits)
//  rst_n is synchronous, active low, and clears only control state
//  the result sits in an output register; a new item is taken while it waits, and
//  the block stalls before writing its next result until that register is free

module prime_field_modular_power_top import pfmp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  pfmp_in_if.sink    in_ch,
  pfmp_out_if.source out_ch
);

  localparam logic [EXP_CNT_W-1:0] ECNT_LAST = EXP_CNT_W'(EXP_W - 1);
  localparam logic [FIELD_W:0]     ORDER_X   = {1'b0, ORDER};
  localparam logic [FIELD_W:0]     PRIME_X   = {1'b0, PRIME};

  pfmp_state_t state_r, state_nxt;

  // exponent magnitude shift register, msb first, and its sign
  logic [EXP_W-1:0]     mag_r, mag_nxt;
  logic                 neg_r, neg_nxt;
  logic [EXP_CNT_W-1:0] ecnt_r, ecnt_nxt;
  // running remainder of the magnitude modulo p-1
  logic [FIELD_W-1:0]   rem_r, rem_nxt;
  // folded exponent, consumed lsb first
  logic [FIELD_W-1:0]   e_r, e_nxt;
  // square-and-multiply operands
  logic [FIELD_W-1:0]   base_r, base_nxt;
  logic [FIELD_W-1:0]   acc_r, acc_nxt;
  // output register
  logic                 ovalid_r, ovalid_nxt;
  logic [FIELD_W-1:0]   power_r, power_nxt;

  logic                 in_take;
  logic [EXP_W-1:0]     mag_in;
  logic [FIELD_W:0]     base_in, rem_dbl;
  logic                 mul_start;
  logic                 mul_done, sqr_done;
  logic [FIELD_W-1:0]   mul_prod, sqr_prod;

  // acc*base and base*base run side by side, one round per exponent bit
  pfmp_mulmod u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (acc_r),
    .op_b    (base_r),
    .done    (mul_done),
    .product (mul_prod)
  );

  pfmp_mulmod u_sqr (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (base_r),
    .op_b    (base_r),
    .done    (sqr_done),
    .product (sqr_prod)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_take      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ovalid_r;
  assign out_ch.power = power_r;

  // two's complement magnitude; the most negative value gives 2^63 unsigned
  assign mag_in  = in_ch.exponent[EXP_W-1] ? (~in_ch.exponent + 64'd1) : in_ch.exponent;
  // a 30-bit base is below 2p, so one subtract reduces it
  assign base_in = {1'b0, in_ch.base};
  // next remainder step before the conditional subtract
  assign rem_dbl = {rem_r, mag_r[EXP_W-1]};

  always_comb begin
    state_nxt  = state_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    ecnt_nxt   = ecnt_r;
    rem_nxt    = rem_r;
    e_nxt      = e_r;
    base_nxt   = base_r;
    acc_nxt    = acc_r;
    ovalid_nxt = ovalid_r;
    power_nxt  = power_r;
    mul_start  = 1'b0;

    if (out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          mag_nxt   = mag_in;
          neg_nxt   = in_ch.exponent[EXP_W-1];
          ecnt_nxt  = '0;
          rem_nxt   = '0;
          base_nxt  = (base_in >= PRIME_X) ? in_ch.base - PRIME : in_ch.base;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        // fold one exponent bit a cycle: rem = 2*rem + bit mod (p-1)
        rem_nxt  = (rem_dbl >= ORDER_X) ? FIELD_W'(rem_dbl - ORDER_X) : rem_dbl[FIELD_W-1:0];
        mag_nxt  = {mag_r[EXP_W-2:0], 1'b0};
        ecnt_nxt = ecnt_r + 1'b1;
        if (ecnt_r == ECNT_LAST) begin
          state_nxt = ST_LIFT;
        end
      end
      ST_LIFT: begin
        // negative exponent: lift the remainder into range for the inverse power
        e_nxt     = (neg_r && (rem_r != '0)) ? ORDER - rem_r : rem_r;
        acc_nxt   = FIELD_W'(1);
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (e_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          mul_start = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mul_done) begin
          if (e_r[0]) begin
            acc_nxt = mul_prod;
          end
          base_nxt  = sqr_prod;
          e_nxt     = {1'b0, e_r[FIELD_W-1:1]};
          state_nxt = ST_ROUND;
        end
      end
      ST_EMIT: begin
        // wait until the output register is free or being drained
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1;
          power_nxt  = acc_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      ecnt_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      ecnt_r   <= ecnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    rem_r   <= rem_nxt;
    e_r     <= e_nxt;
    base_r  <= base_nxt;
    acc_r   <= acc_nxt;
    power_r <= power_nxt;
  end

  // both serial units are started together and must finish together
  assert property (@(posedge clk) disable iff (!rst_n) mul_done == sqr_done)
    else $error("multiply and square units out of step");

  // a round start always leads into the wait for the multipliers
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && e_r != '0) |=> (state_r == ST_WAIT))
    else $error("round start did not enter wait");

  // operands of the square-and-multiply loop stay reduced
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND || state_r == ST_WAIT) |-> (acc_r < PRIME && base_r < PRIME))
    else $error("operand not reduced modulo the prime");

  // the folded exponent never reaches p-1
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REDUCE || state_r == ST_LIFT) |-> (rem_r < ORDER))
    else $error("exponent remainder out of range");

  // the multipliers report done only while the loop waits on them
  assert property (@(posedge clk) disable iff (!rst_n) mul_done |-> (state_r == ST_WAIT))
    else $error("multiplier done outside of wait");

endmodule
